// ===== sv/pid_pkg.sv =====
// Shared types, constants and saturation helpers for the PID controller.
// Used by pid_div, pid_dp, pid_ctrl and pid_controller_antiwindup. No dependencies.
package pid_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int W         = 32;  // field width
	localparam int ACC_W     = 72;  // exact sums of shifted products
	localparam int MUL_W     = 34;  // shared multiplier operand width
	localparam int DIV_NUM_W = 64;  // dividend / quotient width
	localparam int DIV_DEN_W = 33;  // divisor width

	localparam logic [2:0] MODE_FULL    = 3'd0;
	localparam logic [2:0] MODE_DGIVEN  = 3'd1;
	localparam logic [2:0] MODE_IGIVEN  = 3'd2;
	localparam logic [2:0] MODE_BOTH    = 3'd3;
	localparam logic [2:0] MODE_PRELOAD = 3'd4;

	localparam logic [2:0] REG_KP   = 3'd0;
	localparam logic [2:0] REG_KI   = 3'd1;
	localparam logic [2:0] REG_KD   = 3'd2;
	localparam logic [2:0] REG_TAU  = 3'd3;
	localparam logic [2:0] REG_IMIN = 3'd4;
	localparam logic [2:0] REG_IMAX = 3'd5;
	localparam logic [2:0] REG_OMIN = 3'd6;
	localparam logic [2:0] REG_OMAX = 3'd7;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INT_MUL,
		OP_INT_ADD,
		OP_DZERO,
		OP_DIV_RAW,
		OP_WAIT_RAW,
		OP_DIV_ALPHA,
		OP_WAIT_ALPHA,
		OP_FMUL,
		OP_FADD,
		OP_G_KP,
		OP_G_KI,
		OP_G_KD,
		OP_G_ACC,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       dt_zero;
		logic       tau_zero;
		logic       div_done;
		logic       out_free;
	} status_t;

	// saturate to a signed range of eff bits
	function automatic logic signed [W-1:0] sat_eff(input logic signed [ACC_W-1:0] x,
		input int eff);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic signed [ACC_W-1:0] r;
		hi = $signed({{(ACC_W-1){1'b0}}, 1'b1}) <<< (eff - 1);
		hi = hi - $signed({{(ACC_W-1){1'b0}}, 1'b1});
		lo = -hi - $signed({{(ACC_W-1){1'b0}}, 1'b1});
		if (x < lo)
			r = lo;
		else if (x > hi)
			r = hi;
		else
			r = x;
		return r[W-1:0];
	endfunction

	// raise to lo, then lower to hi (hi wins when crossed), then saturate
	function automatic logic signed [W-1:0] clamp_eff(input logic signed [ACC_W-1:0] x,
		input logic signed [W-1:0] lo, input logic signed [W-1:0] hi, input int eff);
		logic signed [ACC_W-1:0] r;
		r = x;
		if (r < ACC_W'(lo))
			r = ACC_W'(lo);
		if (r > ACC_W'(hi))
			r = ACC_W'(hi);
		return sat_eff(r, eff);
	endfunction

endpackage

// ===== sv/pid_div.sv =====
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// Depends on pid_pkg for widths.
module pid_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pid_pkg::DIV_NUM_W-1:0]   dividend,
	input  logic [pid_pkg::DIV_DEN_W-1:0]   divisor,
	output logic [pid_pkg::DIV_NUM_W-1:0]   quotient,
	output logic                            done
);
	localparam int NW = pid_pkg::DIV_NUM_W;
	localparam int DW = pid_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign quotient = quo_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits in DW bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DW'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== sv/pid_dp.sv =====
// Datapath: configuration and state registers, shared multiplier, divider, output register.
// Depends on pid_pkg and pid_div; driven by pid_ctrl commands.
module pid_dp #(
	parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pid_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pid_pkg::cmd_t        cmd,
	output pid_pkg::status_t     status,
	input  logic [127:0]         in_data,
	input  logic [2:0]           in_mode,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [31:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [95:0]          out_data
);
	localparam int EFF   = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam int W     = pid_pkg::W;
	localparam int AW    = pid_pkg::ACC_W;
	localparam int MW    = pid_pkg::MUL_W;
	localparam int NW    = pid_pkg::DIV_NUM_W;
	localparam int DW    = pid_pkg::DIV_DEN_W;

	// configuration
	logic signed [W-1:0] kp_q, ki_q, kd_q, imin_q, imax_q, omin_q, omax_q;
	logic        [W-1:0] tau_q;
	// controller state
	logic signed [W-1:0] perr_q, eint_q, pder_q;
	// work registers
	logic        [2:0]        mode_q;
	logic signed [W-1:0]      e_q, integ_q, deriv_q;
	logic        [W-1:0]      dt_q, alpha_q;
	logic                     sign_q;
	logic signed [2*MW-1:0]   prod_q;
	logic signed [AW-1:0]     acc_q;
	logic                     out_valid_q;
	logic        [95:0]       out_data_q;

	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [AW-1:0]  pshift;
	logic signed [W:0]     diff_e, diff_d;
	logic        [W:0]     mag_e;
	logic                  div_start, div_done;
	logic        [NW-1:0]  div_num, div_quo;
	logic        [DW-1:0]  div_den;
	logic signed [AW-1:0]  quo_signed;
	logic                  out_free, fire;
	logic                  upd_int, upd_der;

	assign out_free = !out_valid_q || out_ready;
	assign fire     = (cmd.op == pid_pkg::OP_FINISH) && out_free;
	assign upd_int  = (mode_q == pid_pkg::MODE_FULL) || (mode_q == pid_pkg::MODE_DGIVEN);
	assign upd_der  = (mode_q == pid_pkg::MODE_FULL) || (mode_q == pid_pkg::MODE_IGIVEN);

	assign status.mode     = mode_q;
	assign status.dt_zero  = (dt_q == '0);
	assign status.tau_zero = (tau_q == '0);
	assign status.div_done = div_done;
	assign status.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign pshift = AW'(prod_q >>> FRAC_BITS);
	assign diff_e = {e_q[W-1], e_q} - {perr_q[W-1], perr_q};
	assign diff_d = {deriv_q[W-1], deriv_q} - {pder_q[W-1], pder_q};
	assign mag_e  = diff_e[W] ? (W+1)'(-diff_e) : diff_e;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			pid_pkg::OP_INT_MUL: begin
				mul_a = MW'(e_q);
				mul_b = $signed({2'b00, dt_q});
			end
			pid_pkg::OP_FMUL: begin
				mul_a = MW'(diff_d);
				mul_b = $signed({2'b00, alpha_q});
			end
			pid_pkg::OP_G_KP: begin
				mul_a = MW'(kp_q);
				mul_b = MW'(e_q);
			end
			pid_pkg::OP_G_KI: begin
				mul_a = MW'(ki_q);
				mul_b = MW'(integ_q);
			end
			pid_pkg::OP_G_KD: begin
				mul_a = MW'(kd_q);
				mul_b = MW'(deriv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		if (cmd.op == pid_pkg::OP_DIV_RAW) begin
			div_start = 1'b1;
			div_num   = NW'(mag_e) << FRAC_BITS;
			div_den   = {1'b0, dt_q};
		end else if (cmd.op == pid_pkg::OP_DIV_ALPHA) begin
			div_start = 1'b1;
			div_num   = NW'(dt_q) << FRAC_BITS;
			div_den   = {1'b0, tau_q} + {1'b0, dt_q};
		end
	end

	assign quo_signed = sign_q ? -AW'(div_quo) : AW'(div_quo);

	pid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.done     (div_done)
	);

	// configuration, stored state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			tau_q       <= '0;
			imin_q      <= {1'b1, {(W-1){1'b0}}};
			imax_q      <= {1'b0, {(W-1){1'b1}}};
			omin_q      <= {1'b1, {(W-1){1'b0}}};
			omax_q      <= {1'b0, {(W-1){1'b1}}};
			perr_q      <= '0;
			eint_q      <= '0;
			pder_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					pid_pkg::REG_KP:   kp_q   <= cfg_data;
					pid_pkg::REG_KI:   ki_q   <= cfg_data;
					pid_pkg::REG_KD:   kd_q   <= cfg_data;
					pid_pkg::REG_TAU:  tau_q  <= cfg_data;
					pid_pkg::REG_IMIN: imin_q <= cfg_data;
					pid_pkg::REG_IMAX: imax_q <= cfg_data;
					pid_pkg::REG_OMIN: omin_q <= cfg_data;
					pid_pkg::REG_OMAX: omax_q <= cfg_data;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (fire) begin
				out_valid_q <= 1'b1;
				if (mode_q <= pid_pkg::MODE_BOTH) begin
					perr_q <= e_q;
					if (upd_int)
						eint_q <= integ_q;
					if (upd_der)
						pder_q <= deriv_q;
				end else if (mode_q == pid_pkg::MODE_PRELOAD) begin
					perr_q <= e_q;
					eint_q <= integ_q;
					pder_q <= '0;
				end
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_mode;
			e_q     <= pid_pkg::sat_eff(AW'($signed(in_data[31:0])), EFF);
			dt_q    <= in_data[63:32];
			deriv_q <= pid_pkg::sat_eff(AW'($signed(in_data[95:64])), EFF);
			integ_q <= pid_pkg::sat_eff(AW'($signed(in_data[127:96])), EFF);
		end
		if (cmd.op == pid_pkg::OP_INT_MUL || cmd.op == pid_pkg::OP_FMUL ||
			cmd.op == pid_pkg::OP_G_KP || cmd.op == pid_pkg::OP_G_KI ||
			cmd.op == pid_pkg::OP_G_KD)
			prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			pid_pkg::OP_INT_ADD:
				integ_q <= pid_pkg::clamp_eff(AW'(eint_q) + pshift, imin_q, imax_q, EFF);
			pid_pkg::OP_DZERO:
				deriv_q <= '0;
			pid_pkg::OP_DIV_RAW:
				sign_q <= diff_e[W];
			pid_pkg::OP_WAIT_RAW:
				if (div_done)
					deriv_q <= pid_pkg::sat_eff(quo_signed, EFF);
			pid_pkg::OP_WAIT_ALPHA:
				if (div_done)
					alpha_q <= div_quo[W-1:0];
			pid_pkg::OP_FADD:
				deriv_q <= pid_pkg::sat_eff(AW'(pder_q) + pshift, EFF);
			pid_pkg::OP_G_KP:
				acc_q <= '0;
			pid_pkg::OP_G_KI, pid_pkg::OP_G_KD, pid_pkg::OP_G_ACC:
				acc_q <= acc_q + pshift;
			default: ;
		endcase
		if (fire) begin
			if (mode_q <= pid_pkg::MODE_BOTH)
				out_data_q <= {deriv_q, integ_q,
					pid_pkg::clamp_eff(acc_q, omin_q, omax_q, EFF)};
			else if (mode_q == pid_pkg::MODE_PRELOAD)
				out_data_q <= {{W{1'b0}}, integ_q, {W{1'b0}}};
			else
				out_data_q <= '0;
		end
	end
endmodule

// ===== sv/pid_ctrl.sv =====
// Sequencer for one controller step: issues datapath commands, branches on status.
// Depends on pid_pkg.
module pid_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pid_pkg::status_t   status,
	output pid_pkg::cmd_t      cmd
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_INT_MUL, ST_INT_ADD, ST_DZERO, ST_DIV_RAW, ST_WAIT_RAW,
		ST_DIV_ALPHA, ST_WAIT_ALPHA, ST_FMUL, ST_FADD, ST_G_KP, ST_G_KI, ST_G_KD,
		ST_G_ACC, ST_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_INT_MUL:    cmd.op = pid_pkg::OP_INT_MUL;
			ST_INT_ADD:    cmd.op = pid_pkg::OP_INT_ADD;
			ST_DZERO:      cmd.op = pid_pkg::OP_DZERO;
			ST_DIV_RAW:    cmd.op = pid_pkg::OP_DIV_RAW;
			ST_WAIT_RAW:   cmd.op = pid_pkg::OP_WAIT_RAW;
			ST_DIV_ALPHA:  cmd.op = pid_pkg::OP_DIV_ALPHA;
			ST_WAIT_ALPHA: cmd.op = pid_pkg::OP_WAIT_ALPHA;
			ST_FMUL:       cmd.op = pid_pkg::OP_FMUL;
			ST_FADD:       cmd.op = pid_pkg::OP_FADD;
			ST_G_KP:       cmd.op = pid_pkg::OP_G_KP;
			ST_G_KI:       cmd.op = pid_pkg::OP_G_KI;
			ST_G_KD:       cmd.op = pid_pkg::OP_G_KD;
			ST_G_ACC:      cmd.op = pid_pkg::OP_G_ACC;
			ST_FIN:        cmd.op = pid_pkg::OP_FINISH;
			default:       cmd.op = pid_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:
					if (in_valid)
						state_q <= ST_DISPATCH;
				ST_DISPATCH: begin
					priority if (status.mode == pid_pkg::MODE_FULL ||
						status.mode == pid_pkg::MODE_DGIVEN)
						state_q <= ST_INT_MUL;
					else if (status.mode == pid_pkg::MODE_IGIVEN)
						state_q <= status.dt_zero ? ST_DZERO : ST_DIV_RAW;
					else if (status.mode == pid_pkg::MODE_BOTH)
						state_q <= ST_G_KP;
					else
						state_q <= ST_FIN;
				end
				ST_INT_MUL:
					state_q <= ST_INT_ADD;
				ST_INT_ADD: begin
					if (status.mode == pid_pkg::MODE_FULL)
						state_q <= status.dt_zero ? ST_DZERO : ST_DIV_RAW;
					else
						state_q <= ST_G_KP;
				end
				ST_DZERO:
					state_q <= ST_G_KP;
				ST_DIV_RAW:
					state_q <= ST_WAIT_RAW;
				ST_WAIT_RAW:
					if (status.div_done)
						state_q <= status.tau_zero ? ST_G_KP : ST_DIV_ALPHA;
				ST_DIV_ALPHA:
					state_q <= ST_WAIT_ALPHA;
				ST_WAIT_ALPHA:
					if (status.div_done)
						state_q <= ST_FMUL;
				ST_FMUL:
					state_q <= ST_FADD;
				ST_FADD:
					state_q <= ST_G_KP;
				ST_G_KP:
					state_q <= ST_G_KI;
				ST_G_KI:
					state_q <= ST_G_KD;
				ST_G_KD:
					state_q <= ST_G_ACC;
				ST_G_ACC:
					state_q <= ST_FIN;
				ST_FIN:
					if (status.out_free)
						state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/pid_controller_antiwindup.sv =====
// Top level of the PID controller with integral clamp and filtered derivative.
// Depends on pid_pkg, pid_ctrl, pid_dp (which holds pid_div).
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the mode in s_tuser and the error,
//   time step, supplied derivative and supplied integral in s_tdata. Each item gives
//   one result item on m_tvalid/m_tready: saturated drive, integral used, derivative
//   used. Gains, filter constant and limits are written through cfg_we/cfg_addr/
//   cfg_data while no item is in flight.
//   One item is worked on at a time; s_tready is high only while the sequencer idles.
//   Preload and unused modes go straight to the finishing step; mode 3 runs only the
//   gain steps, mode 1 adds the integral update, and a full step adds the derivative,
//   which needs no division for a zero time step. Each division is started by the
//   sequencer and then runs in the shared bit-serial divider; a filtered
//   derivative needs two of them, an unfiltered one needs one. The next item can be
//   accepted as soon as the result lands in the output register.
//   The result sits in an output register; a new item is taken while it waits, and
//   the sequencer only stalls at its last step if that register is still full.
//   Reset (arst_n low) clears the stored error, integral and derivative, sets the
//   gains and filter constant to zero and opens the limits to the full range.
module pid_controller_antiwindup #(
	parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pid_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// error_sample[31:0], time_step[63:32], derivative_in[95:64], integral_in[127:96]
	input  logic [127:0] s_tdata,
	// mode[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// drive_out[31:0], integral_now[63:32], derivative_now[95:64]
	output logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_data
);
	pid_pkg::cmd_t    cmd;
	pid_pkg::status_t status;

	// sequencer: one step per item, branching on mode, dt and tau
	pid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic, stored state and output register
	pid_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.in_mode   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// one item at a time: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous one in flight");

	// a finishing step always lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pid_pkg::OP_FINISH) && status.out_free |=> m_tvalid)
		else $error("finished step did not produce a result");

	// divider cannot report done right after a start
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pid_pkg::OP_DIV_RAW || cmd.op == pid_pkg::OP_DIV_ALPHA)
		|=> !status.div_done)
		else $error("divider done too early");
endmodule

// ===== tb/tb.sv =====
// Testbench for pid_controller_antiwindup: directed table plus random items,
// all checked against an in-bench PID predictor. Depends on pid_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

	localparam int FB = 16;
	localparam int N_RANDOM = 900;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] integ;
		logic signed [31:0] deriv;
	} pid_out_t;

	typedef struct {
		logic [2:0]  mode;
		logic [31:0] err;
		logic [31:0] dt;
		logic [31:0] d_in;
		logic [31:0] i_in;
		bit          has_exp;
		pid_out_t    exp;
	} vec_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [31:0]  cfg_data;

	pid_controller_antiwindup uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	// predictor copy of registers and state
	longint kp, ki, kd, imin, imax, omin, omax;
	longint tau;
	longint prev_err, integ_acc, prev_deriv;

	pid_out_t expected_q[$];
	int       mismatches;
	int       watchdog;
	bit       hold_rx;      // long receiver hold-off requested

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint fshift(longint x);
		return x >>> FB;  // arithmetic: floor
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint clamp_to(longint x, longint lo, longint hi);
		if (x < lo) x = lo;
		if (x > hi) x = hi;
		return sat32(x);
	endfunction

	// advance predictor by one item, return the drive/integral/derivative
	function automatic pid_out_t pid_predict(logic [2:0] mode, logic [31:0] err_bits,
		logic [31:0] dt_bits, logic [31:0] din_bits, logic [31:0] iin_bits);
		pid_out_t r;
		longint e, dt, integ, deriv, drive, num, alpha, t;
		e = longint'($signed(err_bits));
		dt = longint'(dt_bits);
		integ = 0;
		deriv = 0;
		drive = 0;
		if (mode <= pid_pkg::MODE_BOTH) begin
			if (mode == pid_pkg::MODE_FULL || mode == pid_pkg::MODE_DGIVEN) begin
				integ_acc = clamp_to(integ_acc + fshift(e * dt), imin, imax);
				integ = integ_acc;
			end else begin
				integ = longint'($signed(iin_bits));
			end
			if (mode == pid_pkg::MODE_FULL || mode == pid_pkg::MODE_IGIVEN) begin
				if (dt > 0) begin
					num = (e - prev_err) * (64'sd1 << FB);
					deriv = sat32(num / dt);  // truncates toward zero
					if (tau != 0) begin
						alpha = (dt << FB) / (tau + dt);
						t = (deriv - prev_deriv) * alpha;
						deriv = sat32(prev_deriv + fshift(t));
					end
				end
				prev_deriv = deriv;
			end else begin
				deriv = longint'($signed(din_bits));
			end
			drive = fshift(kp * e) + fshift(ki * integ) + fshift(kd * deriv);
			drive = clamp_to(drive, omin, omax);
			prev_err = e;
		end else if (mode == pid_pkg::MODE_PRELOAD) begin
			prev_err = e;
			integ_acc = longint'($signed(iin_bits));
			prev_deriv = 0;
			integ = integ_acc;
		end
		r.drive = drive[31:0];
		r.integ = integ[31:0];
		r.deriv = deriv[31:0];
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pid_pkg::REG_KP:   kp = longint'($signed(val));
			pid_pkg::REG_KI:   ki = longint'($signed(val));
			pid_pkg::REG_KD:   kd = longint'($signed(val));
			pid_pkg::REG_TAU:  tau = longint'(val);
			pid_pkg::REG_IMIN: imin = longint'($signed(val));
			pid_pkg::REG_IMAX: imax = longint'($signed(val));
			pid_pkg::REG_OMIN: omin = longint'($signed(val));
			pid_pkg::REG_OMAX: omax = longint'($signed(val));
			default: ;
		endcase
	endtask

	// block is idle only once the result queue drained; every item yields a result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one item, wait for acceptance; optionally check a typed-in expectation
	// tvalid stays high after the accept unless a gap follows or the input idles
	task automatic send_item(vec_t v);
		pid_out_t p;
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p = pid_predict(v.mode, v.err, v.dt, v.d_in, v.i_in);
		if (v.has_exp && p != v.exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display("directed row: table %h predictor %h", v.exp, p);
		end
		s_tvalid <= 1'b1;
		s_tuser <= v.mode;
		s_tdata <= {v.i_in, v.d_in, v.dt, v.err};
		expected_q.push_back(p);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'($signed($urandom_range(0, 8000)) - 4000);
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_t rand_item();
		vec_t v;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12) v.mode = pid_pkg::MODE_FULL;
		else if (pick < 19) v.mode = 3'($urandom_range(1, 4));
		else v.mode = 3'($urandom_range(5, 7));
		v.err = rand_word();
		v.dt = ($urandom_range(0, 3) == 0) ? rand_word() : 32'($urandom_range(0, 32'h0002_0000));
		v.d_in = rand_word();
		v.i_in = rand_word();
		v.has_exp = 1'b0;
		return v;
	endfunction

	// receiver: random stalls plus a long hold-off on request
	initial begin
		pid_out_t got;
		int stall;
		m_tready = 1'b0;
		mismatches = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_rx = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			repeat (stall) @(posedge clk);
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.drive = m_tdata[31:0];
			got.integ = m_tdata[63:32];
			got.deriv = m_tdata[95:64];
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				pid_out_t want;
				want = expected_q.pop_front();
				if (got.drive !== want.drive || got.integ !== want.integ
					|| got.deriv !== want.deriv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
			m_tready <= 1'b0;
		end
	end

	// watchdog: cycles without any accepted item or taken result, outside a hold-off
	initial begin
		watchdog = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_rx)
				watchdog = 0;
			else
				watchdog++;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	vec_t table_rows[$];

	initial begin
		vec_t v;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pid_pkg::MODE_FULL;
		cfg_we = 1'b0;
		cfg_addr = pid_pkg::REG_KP;
		cfg_data = '0;
		hold_rx = 1'b0;
		kp = 0; ki = 0; kd = 0; tau = 0;
		imin = -64'sd2147483648; imax = 64'sd2147483647;
		omin = -64'sd2147483648; omax = 64'sd2147483647;
		prev_err = 0; integ_acc = 0; prev_deriv = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: {mode, err, dt, d_in, i_in, has_exp, {drive, integ, deriv}}
		// gains zero after reset: drive is 0, integral/derivative readable
		table_rows = '{
			'{pid_pkg::MODE_FULL, 32'h0001_0000, 32'h0001_0000, 0, 0, 1,
				'{0, 32'h0001_0000, 32'h0001_0000}},
			'{pid_pkg::MODE_FULL, 32'h0001_0000, 32'h0000_0000, 0, 0, 1,
				'{0, 32'h0001_0000, 0}},
			'{pid_pkg::MODE_PRELOAD, 32'h7FFF_FFFF, 32'h1234_5678, 5, 32'h8000_0000, 1,
				'{0, 32'h8000_0000, 0}},
			'{3'd5, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7, 7, 1, '{0, 0, 0}},
			'{3'd7, 32'h8000_0000, 32'hFFFF_FFFF, 7, 7, 1, '{0, 0, 0}},
			'{pid_pkg::MODE_BOTH, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
				32'h8000_0000, 1, '{0, 32'h8000_0000, 32'h7FFF_FFFF}},
			'{pid_pkg::MODE_DGIVEN, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, '0},
			'{pid_pkg::MODE_IGIVEN, 32'h7FFF_FFFF, 32'h0000_0001, 0, 32'h7FFF_FFFF, 0, '0},
			'{pid_pkg::MODE_FULL, 32'h8000_0000, 32'h0000_0001, 0, 0, 0, '0},
			'{pid_pkg::MODE_FULL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, '0}
		};
		foreach (table_rows[i]) send_item(table_rows[i]);
		wait_drained();

		// extreme gains, filter on, crossed integral limits (max wins)
		write_reg(pid_pkg::REG_KP, 32'h7FFF_FFFF);
		write_reg(pid_pkg::REG_KI, 32'h8000_0000);
		write_reg(pid_pkg::REG_KD, 32'h0001_0000);
		write_reg(pid_pkg::REG_TAU, 32'hFFFF_FFFF);
		write_reg(pid_pkg::REG_IMIN, 32'h0010_0000);
		write_reg(pid_pkg::REG_IMAX, 32'hFFF0_0000);
		write_reg(pid_pkg::REG_OMIN, 32'h8000_0000);
		write_reg(pid_pkg::REG_OMAX, 32'h7FFF_FFFF);
		for (int i = 0; i < 10; i++) begin
			v = rand_item();
			v.mode = 3'(i % 5);
			send_item(v);
		end
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			write_reg(pid_pkg::REG_KP,
				(phase == 3) ? 32'h8000_0000 : 32'($urandom_range(0, 32'h0004_0000)));
			write_reg(pid_pkg::REG_KI, $urandom);
			write_reg(pid_pkg::REG_KD,
				32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
			write_reg(pid_pkg::REG_TAU,
				(phase[0]) ? 32'h0 : 32'($urandom_range(1, 32'h0004_0000)));
			write_reg(pid_pkg::REG_IMIN, (phase == 2) ? 32'hFFFE_0000 : 32'h8000_0000);
			write_reg(pid_pkg::REG_IMAX, (phase == 2) ? 32'h0002_0000 : 32'h7FFF_FFFF);
			write_reg(pid_pkg::REG_OMIN, (phase == 1) ? 32'h0005_0000 : 32'hFFF0_0000);
			write_reg(pid_pkg::REG_OMAX, (phase == 1) ? 32'hFFFB_0000 : 32'h0010_0000);
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				if (phase == 1 && i == 20) hold_rx = 1'b1;
				if (phase == 2 && i == 100) wait_drained();
				send_item(rand_item());
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
